// ===== sv/rle_pkg.sv =====
`default_nettype none

package rle_pkg;

	// default right edge of the column window
	localparam int unsigned LAST_COLUMN_DEF = 127;

	// controller command bytes
	localparam logic [7:0] CMD_MEMORY_MODE   = 8'h20;
	localparam logic [7:0] MEM_MODE_VERTICAL = 8'h01;
	localparam logic [7:0] CMD_COLUMN_ADDR   = 8'h21;
	localparam logic [7:0] CMD_PAGE_ADDR     = 8'h22;

	// action codes
	localparam logic ACT_START = 1'b0;
	localparam logic ACT_RUN   = 1'b1;

	// run code layout
	localparam int unsigned RUN_LEN_W = 7;

	typedef struct packed {
		logic       action;
		logic [6:0] column_start;
		logic [2:0] page_start;
		logic [6:0] icon_height;
		logic [7:0] run_code;
		logic       final_run;
	} item_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       is_data;
		logic       last_of_run;
	} result_t;

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_CMD  = 3'b010,
		ST_RUN  = 3'b100
	} state_t;

	// control from the top level to the bit packer
	typedef struct packed {
		logic start;
		logic load;
		logic active;
		logic out_ready;
	} pack_ctrl_t;

	// status from a byte source back to the top level
	typedef struct packed {
		logic emit;
		logic done;
	} src_stat_t;

endpackage

`default_nettype wire

// ===== sv/rle_cmd_seq.sv =====
`default_nettype none

module rle_cmd_seq #(
	parameter int unsigned LAST_COLUMN = rle_pkg::LAST_COLUMN_DEF
) (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            load,
	input  wire rle_pkg::item_t  item,
	input  wire logic            step,
	output rle_pkg::src_stat_t   stat,
	output rle_pkg::result_t     res
);
	import rle_pkg::*;

	localparam logic [7:0] LastCol = 8'(LAST_COLUMN);

	logic [2:0] idx_q;
	logic [6:0] col_q;
	logic [2:0] page_q;
	logic [7:0] page_end_q;
	logic [7:0] cmd_byte;

	// capture the window on a start transaction, then walk the eight command bytes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= '0;
		end else if (load) begin
			idx_q <= '0;
		end else if (step) begin
			idx_q <= idx_q + 3'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			col_q      <= item.column_start;
			page_q     <= item.page_start;
			page_end_q <= 8'({5'd0, item.page_start} + {4'd0, item.icon_height[6:3]} + 8'hFF);
		end
	end

	// command byte for the current slot
	always_comb begin
		unique case (idx_q)
			3'd0:    cmd_byte = CMD_MEMORY_MODE;
			3'd1:    cmd_byte = MEM_MODE_VERTICAL;
			3'd2:    cmd_byte = CMD_COLUMN_ADDR;
			3'd3:    cmd_byte = {1'b0, col_q};
			3'd4:    cmd_byte = LastCol;
			3'd5:    cmd_byte = CMD_PAGE_ADDR;
			3'd6:    cmd_byte = {5'd0, page_q};
			3'd7:    cmd_byte = page_end_q;
			default: cmd_byte = CMD_MEMORY_MODE;
		endcase
	end

	assign res.out_byte    = cmd_byte;
	assign res.is_data     = 1'b0;
	assign res.last_of_run = (idx_q == 3'd7);
	assign stat.emit       = step;
	assign stat.done       = step && (idx_q == 3'd7);

endmodule

`default_nettype wire

// ===== sv/rle_bit_packer.sv =====
`default_nettype none

module rle_bit_packer (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire rle_pkg::pack_ctrl_t ctrl,
	input  wire logic [7:0]         run_code,
	input  wire logic               final_run,
	output rle_pkg::src_stat_t      stat,
	output rle_pkg::result_t        res
);
	import rle_pkg::*;

	logic [RUN_LEN_W-1:0] rem_q;
	logic                 bit_q;
	logic                 fin_q;
	logic [6:0]           sr_q;
	logic [2:0]           pos_q;
	logic                 step;
	logic                 full;

	// one bit per cycle; the completing bit waits for room in the output register
	assign full = (pos_q == 3'd7);
	assign step = ctrl.active && (rem_q != '0) && (!full || ctrl.out_ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rem_q <= '0;
			pos_q <= '0;
			fin_q <= 1'b0;
		end else if (ctrl.start) begin
			pos_q <= '0;
		end else if (ctrl.load) begin
			rem_q <= run_code[RUN_LEN_W-1:0];
			fin_q <= final_run;
		end else if (step) begin
			rem_q <= rem_q - RUN_LEN_W'(1);
			pos_q <= pos_q + 3'd1;
		end else if (ctrl.active && fin_q && (rem_q == '0)) begin
			// final run drops the partial byte once all its bits are in
			pos_q <= '0;
		end
	end

	// lsb-first shift line; after seven shifts it holds bits 0..6 of the byte
	always_ff @(posedge clk) begin
		if (ctrl.load) begin
			bit_q <= run_code[7];
		end
		if (step) begin
			sr_q <= {bit_q, sr_q[6:1]};
		end
	end

	assign res.out_byte    = {bit_q, sr_q};
	assign res.is_data     = 1'b1;
	assign res.last_of_run = (rem_q <= 7'd8);
	assign stat.emit       = step && full;
	assign stat.done       = ctrl.active && (rem_q == '0);

endmodule

`default_nettype wire

// ===== sv/rle_icon_to_oled_stream.sv =====
// a start transaction sets the state register, then its command bytes go to the output register,
// one command byte per cycle while the output is not stalled, before the next item is taken
// a run transaction feeds the bit-serial packer one run bit at a time before the next item is taken
// a data byte is registered at the edge that takes its eighth bit; output stalls pause the packer
// arst_n clears the control state and the packer position; no clearing pass is needed
`default_nettype none

module rle_icon_to_oled_stream #(
	parameter int unsigned LAST_COLUMN = rle_pkg::LAST_COLUMN_DEF
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             item_valid,
	output logic                  item_stall,
	input  wire rle_pkg::item_t   item,
	output logic                  result_valid,
	input  wire logic             result_stall,
	output rle_pkg::result_t      result
);
	import rle_pkg::*;

	state_t     state_q;
	logic       accept;
	logic       out_ready;
	logic       res_valid_q;
	result_t    res_q;
	pack_ctrl_t pctrl;
	src_stat_t  cmd_stat;
	src_stat_t  pack_stat;
	result_t    cmd_res;
	result_t    pack_res;
	logic       cmd_step;

	assign item_stall = (state_q != ST_IDLE);
	assign accept     = item_valid && !item_stall;
	assign out_ready  = !res_valid_q || !result_stall;
	assign cmd_step   = (state_q == ST_CMD) && out_ready;

	assign pctrl.start     = accept && (item.action == ACT_START);
	assign pctrl.load      = accept && (item.action == ACT_RUN);
	assign pctrl.active    = (state_q == ST_RUN);
	assign pctrl.out_ready = out_ready;

	rle_cmd_seq #(
		.LAST_COLUMN(LAST_COLUMN)
	) u_cmd (
		.clk   (clk),
		.arst_n(arst_n),
		.load  (pctrl.start),
		.item  (item),
		.step  (cmd_step),
		.stat  (cmd_stat),
		.res   (cmd_res)
	);

	rle_bit_packer u_pack (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctrl     (pctrl),
		.run_code (item.run_code),
		.final_run(item.final_run),
		.stat     (pack_stat),
		.res      (pack_res)
	);

	// one item at a time
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q <= (item.action == ACT_START) ? ST_CMD : ST_RUN;
					end
				end
				ST_CMD: begin
					if (cmd_stat.done) begin
						state_q <= ST_IDLE;
					end
				end
				ST_RUN: begin
					if (pack_stat.done) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (cmd_stat.emit || pack_stat.emit) begin
			res_valid_q <= 1'b1;
		end else if (!result_stall) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_stat.emit) begin
			res_q <= cmd_res;
		end else if (pack_stat.emit) begin
			res_q <= pack_res;
		end
	end

	assign result_valid = res_valid_q;
	assign result       = res_q;

`ifndef NO_ASSERTIONS
	// a byte is only produced when the output register can take it
	a_emit_room: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd_stat.emit || pack_stat.emit) |-> out_ready)
		else $error("byte produced while output register is held");

	// the two byte sources never fire together
	a_one_src: assert property (@(posedge clk) disable iff (!arst_n)
		!(cmd_stat.emit && pack_stat.emit))
		else $error("command and data bytes produced in the same cycle");

	// a start transaction leads to the command sequence
	a_start_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && (item.action == ACT_START)) |=> (state_q == ST_CMD))
		else $error("start transaction did not enter command sequence");
`endif

endmodule

`default_nettype wire

// ===== sim/tb_rle_icon_to_oled_stream.sv =====
`timescale 1ns / 100ps

module tb_rle_icon_to_oled_stream;
	import rle_pkg::*;

	localparam int unsigned LAST_COL      = 127;
	localparam logic [7:0]  LAST_COL_BYTE = 8'(LAST_COL);
	localparam int          RANDOM_ITEMS  = 260;
	localparam int          CALM_FIRST    = 150;
	localparam int          CALM_LAST     = 215;

	// one stimulus row; n_typed < 0 means the predictor supplies the bytes
	typedef struct {
		item_t       it;
		int          n_typed;
		logic [63:0] typed_bytes;
	} icon_row_t;

	logic    clk;
	logic    arst_n       = 1'b0;
	logic    item_valid   = 1'b0;
	logic    item_stall;
	item_t   item         = '0;
	logic    result_valid;
	logic    result_stall = 1'b0;
	result_t result;

	// packer state of the predictor
	logic [6:0] pix_acc;
	logic [2:0] pix_pos;

	result_t   step_bytes[$];
	result_t   oled_bytes_due[$];
	icon_row_t icon_rows[$];
	result_t   oldest_byte;
	logic      calm     = 1'b0;
	int        fail_count = 0;

	rle_icon_to_oled_stream #(
		.LAST_COLUMN(LAST_COL)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.item_valid(item_valid),
		.item_stall(item_stall),
		.item(item),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.result(result)
	);

	// clock
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// watchdog
	initial begin
		#8000000;
		$display("simulation failed");
		$finish;
	end

	function automatic void add_byte(input logic [7:0] b, input logic data);
		result_t r;
		r.out_byte    = b;
		r.is_data     = data;
		r.last_of_run = 1'b0;
		step_bytes.push_back(r);
	endfunction

	// predicts the bytes one transaction causes and advances the packer
	function automatic void decode_icon_item(input item_t it);
		logic [7:0]  page_end;
		logic        px;
		int unsigned len;
		result_t     r;
		step_bytes.delete();
		if (it.action == ACT_START) begin
			page_end = 8'(it.page_start) + 8'(it.icon_height >> 3) + 8'hFF;
			add_byte(CMD_MEMORY_MODE, 1'b0);
			add_byte(MEM_MODE_VERTICAL, 1'b0);
			add_byte(CMD_COLUMN_ADDR, 1'b0);
			add_byte(8'(it.column_start), 1'b0);
			add_byte(LAST_COL_BYTE, 1'b0);
			add_byte(CMD_PAGE_ADDR, 1'b0);
			add_byte(8'(it.page_start), 1'b0);
			add_byte(page_end, 1'b0);
			pix_acc = '0;
			pix_pos = '0;
		end else begin
			px  = it.run_code[7];
			len = {25'd0, it.run_code[RUN_LEN_W-1:0]};
			for (int j = 0; j < len; j++) begin
				if (pix_pos < 3'd7) begin
					pix_acc[pix_pos] = px;
					pix_pos++;
				end else begin
					add_byte({px, pix_acc}, 1'b1);
					pix_acc = '0;
					pix_pos = '0;
				end
			end
			// final run drops the partial byte
			if (it.final_run) begin
				pix_acc = '0;
				pix_pos = '0;
			end
		end
		if (step_bytes.size() > 0) begin
			r = step_bytes.pop_back();
			r.last_of_run = 1'b1;
			step_bytes.push_back(r);
		end
	endfunction

	function automatic void add_row(input logic act, input logic [6:0] col,
		input logic [2:0] pg, input logic [6:0] ht, input logic [7:0] code,
		input logic fin, input int n_typed, input logic [63:0] typed_bytes);
		icon_row_t row;
		row.it.action       = act;
		row.it.column_start = col;
		row.it.page_start   = pg;
		row.it.icon_height  = ht;
		row.it.run_code     = code;
		row.it.final_run    = fin;
		row.n_typed         = n_typed;
		row.typed_bytes     = typed_bytes;
		icon_rows.push_back(row);
	endfunction

	function automatic logic [7:0] pick_run_code();
		logic [6:0] len;
		if ($urandom_range(0, 3) == 0)
			len = 7'($urandom_range(0, 127));
		else
			len = 7'($urandom_range(0, 24));
		return {1'($urandom_range(0, 1)), len};
	endfunction

	function automatic logic [6:0] pick_height();
		if ($urandom_range(0, 3) == 0)
			return 7'($urandom_range(0, 127));
		return 7'(8 * $urandom_range(1, 8));
	endfunction

	// offers one transaction, waits for acceptance, then queues its bytes
	task automatic send_row(input icon_row_t row);
		int unsigned gap;
		result_t     r;
		gap = 0;
		if (!calm)
			while ($urandom_range(0, 99) < 28) gap++;
		if (gap > 0) begin
			item_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		item_valid <= 1'b1;
		item       <= row.it;
		do @(posedge clk); while (item_stall);
		decode_icon_item(row.it);
		if (row.n_typed < 0) begin
			foreach (step_bytes[k]) oled_bytes_due.push_back(step_bytes[k]);
		end else begin
			for (int k = 0; k < row.n_typed; k++) begin
				r.out_byte    = row.typed_bytes[8*(row.n_typed-1-k) +: 8];
				r.is_data     = (row.it.action == ACT_RUN);
				r.last_of_run = (k == row.n_typed - 1);
				oled_bytes_due.push_back(r);
			end
		end
	endtask

	// directed rows, random icons, then drain
	initial begin
		int          sel;
		int          nruns;
		int          rand_count;
		int          w;
		logic [6:0]  ht;

		pix_acc = '0;
		pix_pos = '0;

		// run straight after reset
		add_row(ACT_RUN, 7'd0, 3'd0, 7'd0, 8'h88, 1'b0, 1, 64'hFF);
		// start extremes and small height
		add_row(ACT_START, 7'd0, 3'd0, 7'd0, 8'h00, 1'b0, 8,
			{CMD_MEMORY_MODE, MEM_MODE_VERTICAL, CMD_COLUMN_ADDR, 8'h00,
			LAST_COL_BYTE, CMD_PAGE_ADDR, 8'h00, 8'hFF});
		add_row(ACT_START, 7'd127, 3'd7, 7'd127, 8'h00, 1'b0, 8,
			{CMD_MEMORY_MODE, MEM_MODE_VERTICAL, CMD_COLUMN_ADDR, 8'h7F,
			LAST_COL_BYTE, CMD_PAGE_ADDR, 8'h07, 8'h15});
		add_row(ACT_START, 7'd64, 3'd7, 7'd64, 8'h00, 1'b0, 8,
			{CMD_MEMORY_MODE, MEM_MODE_VERTICAL, CMD_COLUMN_ADDR, 8'h40,
			LAST_COL_BYTE, CMD_PAGE_ADDR, 8'h07, 8'h0E});
		add_row(ACT_START, 7'd5, 3'd3, 7'd7, 8'h00, 1'b0, 8,
			{CMD_MEMORY_MODE, MEM_MODE_VERTICAL, CMD_COLUMN_ADDR, 8'h05,
			LAST_COL_BYTE, CMD_PAGE_ADDR, 8'h03, 8'h02});
		add_row(ACT_RUN, 7'd0, 3'd0, 7'd0, 8'h08, 1'b0, 1, 64'h00);
		// zero-length runs, plain and final, then short runs that fill one byte
		add_row(ACT_RUN, 7'd0, 3'd0, 7'd0, 8'h00, 1'b0, 0, 64'h0);
		add_row(ACT_RUN, 7'd0, 3'd0, 7'd0, 8'h80, 1'b1, 0, 64'h0);
		add_row(ACT_RUN, 7'd0, 3'd0, 7'd0, 8'h83, 1'b0, 0, 64'h0);
		add_row(ACT_RUN, 7'd0, 3'd0, 7'd0, 8'h05, 1'b1, 1, 64'h07);
		add_row(ACT_RUN, 7'd0, 3'd0, 7'd0, 8'h85, 1'b0, -1, 64'h0);
		// start mid-icon with junk in the run fields
		add_row(ACT_START, 7'd10, 3'd2, 7'd24, 8'hFF, 1'b1, 8,
			{CMD_MEMORY_MODE, MEM_MODE_VERTICAL, CMD_COLUMN_ADDR, 8'h0A,
			LAST_COL_BYTE, CMD_PAGE_ADDR, 8'h02, 8'h04});
		add_row(ACT_RUN, 7'd0, 3'd0, 7'd0, 8'h84, 1'b0, -1, 64'h0);
		add_row(ACT_RUN, 7'd0, 3'd0, 7'd0, 8'h0C, 1'b0, -1, 64'h0);
		// longest run from bit slot seven gives sixteen bytes
		add_row(ACT_RUN, 7'd0, 3'd0, 7'd0, 8'h07, 1'b0, -1, 64'h0);
		add_row(ACT_RUN, 7'd0, 3'd0, 7'd0, 8'hFF, 1'b0, -1, 64'h0);
		add_row(ACT_RUN, 7'd127, 3'd7, 7'd127, 8'h7F, 1'b1, -1, 64'h0);
		add_row(ACT_RUN, 7'd127, 3'd7, 7'd127, 8'h81, 1'b0, -1, 64'h0);
		add_row(ACT_START, 7'd127, 3'd0, 7'd8, 8'h00, 1'b0, 8,
			{CMD_MEMORY_MODE, MEM_MODE_VERTICAL, CMD_COLUMN_ADDR, 8'h7F,
			LAST_COL_BYTE, CMD_PAGE_ADDR, 8'h00, 8'h00});
		add_row(ACT_RUN, 7'd0, 3'd0, 7'd0, 8'h88, 1'b0, 1, 64'hFF);
		add_row(ACT_RUN, 7'd0, 3'd0, 7'd0, 8'hFF, 1'b1, -1, 64'h0);

		// random icons, mostly well formed, some stray runs and restarts
		rand_count = 0;
		while (rand_count < RANDOM_ITEMS) begin
			sel = $urandom_range(0, 99);
			if (sel < 80) begin
				ht = pick_height();
				add_row(ACT_START, 7'($urandom_range(0, 127)), 3'($urandom_range(0, 7)),
					ht, 8'($urandom), 1'($urandom_range(0, 1)), -1, 64'h0);
				nruns = $urandom_range(1, 12);
				for (int k = 0; k < nruns; k++)
					add_row(ACT_RUN, 7'($urandom), 3'($urandom), 7'($urandom),
						pick_run_code(), (k == nruns - 1), -1, 64'h0);
				rand_count += nruns + 1;
			end else if (sel < 90) begin
				add_row(ACT_RUN, 7'($urandom), 3'($urandom), 7'($urandom),
					pick_run_code(), 1'($urandom_range(0, 1)), -1, 64'h0);
				rand_count++;
			end else begin
				add_row(ACT_START, 7'($urandom_range(0, 127)), 3'($urandom_range(0, 7)),
					7'($urandom_range(0, 127)), 8'($urandom), 1'($urandom_range(0, 1)),
					-1, 64'h0);
				rand_count++;
			end
		end

		// reset
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (icon_rows[i]) begin
			calm = (i >= CALM_FIRST && i < CALM_LAST);
			send_row(icon_rows[i]);
		end
		item_valid <= 1'b0;
		calm = 1'b0;

		// drain, then watch for stray bytes
		w = 0;
		while (oled_bytes_due.size() != 0 && w < 200000) begin
			@(posedge clk);
			w++;
		end
		repeat (160) @(posedge clk);
		if (oled_bytes_due.size() != 0) begin
			$error("%0d expected bytes never arrived", oled_bytes_due.size());
			fail_count++;
		end

		if (fail_count == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

	// output stall, random outside the calm stretch
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			result_stall <= 1'b0;
		else
			result_stall <= !calm && ($urandom_range(0, 99) < 28);
	end

	// compare each output transaction with the oldest expected byte
	always @(posedge clk) begin
		if (arst_n && result_valid && !result_stall) begin
			if (oled_bytes_due.size() == 0) begin
				$error("unexpected byte: out_byte %02h is_data %0b",
					result.out_byte, result.is_data);
				fail_count++;
			end else begin
				oldest_byte = oled_bytes_due.pop_front();
				if (result.out_byte !== oldest_byte.out_byte) begin
					$error("out_byte: expected %02h, actual %02h",
						oldest_byte.out_byte, result.out_byte);
					fail_count++;
				end
				if (result.is_data !== oldest_byte.is_data) begin
					$error("is_data: expected %0b, actual %0b",
						oldest_byte.is_data, result.is_data);
					fail_count++;
				end
				if (result.last_of_run !== oldest_byte.last_of_run) begin
					$error("last_of_run: expected %0b, actual %0b",
						oldest_byte.last_of_run, result.last_of_run);
					fail_count++;
				end
			end
		end
	end

endmodule
